/* src/assert_macros.svh */
// Assertion macros used by the matcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define LOBM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("matcher check failed");

// Clocked check that also runs during reset.
`define LOBM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("matcher check failed");

`endif

/* src/lobm_pkg.sv */
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lobm_pkg;

    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 32;
    localparam int TRADER_W = 16;
    localparam int SEQ_W    = 32;

    localparam logic KIND_LIMIT  = 1'b0;
    localparam logic KIND_MARKET = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;

    localparam logic RES_TRADE = 1'b0;
    localparam logic RES_FINAL = 1'b1;

    localparam logic [1:0] ST_OPEN     = 2'd0;
    localparam logic [1:0] ST_PARTIAL  = 2'd1;
    localparam logic [1:0] ST_FILLED   = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    typedef struct packed {
        logic                kind;
        logic                side;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    quantity;
        logic [TRADER_W-1:0] trader;
    } t_order;

    typedef struct packed {
        logic                result_type;
        logic [SEQ_W-1:0]    order_number;
        logic [SEQ_W-1:0]    trade_number;
        logic [TRADER_W-1:0] maker_trader;
        logic [SEQ_W-1:0]    maker_order;
        logic [TRADER_W-1:0] taker_trader;
        logic                taker_dir;
        logic [PRICE_W-1:0]  fill_price;
        logic [QTY_W-1:0]    trade_qty;
        logic [1:0]          order_status;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    remaining;
        logic [TRADER_W-1:0] owner;
        logic [SEQ_W-1:0]    seq;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_run;
        logic fill;
        logic report;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic more;
        logic out_free;
    } t_dp_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_SCAN,
        S_DECIDE,
        S_FILL,
        S_REPORT
    } t_state;

endpackage

`default_nettype wire

/* src/lobm_ctrl.sv */
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer for one order: repeated book scans, fills and the final report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lobm_ctrl
    import lobm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.more ? S_START : S_REPORT;
            end
            S_START: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = i_sts.found ? S_FILL : S_REPORT;
            end
            S_FILL: begin
                if (i_sts.out_free) n_state = S_CHECK;
            end
            S_REPORT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_START: begin
                o_cmd.scan_init = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
            end
            S_FILL: begin
                o_cmd.fill = i_sts.out_free;
            end
            S_REPORT: begin
                o_cmd.report = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/lobm_dp.sv */
// ----------------------------------------------------------------------------
// lobm_dp
// Book storage, best-entry scan, fill arithmetic and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lobm_dp
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = 32
)(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_order  i_order,
    input  wire logic    i_out_stall,
    output t_dp_sts      o_sts,
    output logic         o_out_valid,
    output t_result      o_out_data
);

    localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int MW = $clog2(2 * BOOK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);
    localparam logic [MW-1:0] ASK_BASE = MW'(BOOK_DEPTH);

    // Bids occupy the lower half of the store, asks the upper half.
    t_entry r_mem [0:2*BOOK_DEPTH-1];

    logic [BOOK_DEPTH-1:0] r_bid_vld;
    logic [BOOK_DEPTH-1:0] r_ask_vld;

    logic                r_kind;
    logic                r_side;
    logic [PRICE_W-1:0]  r_limit;
    logic [QTY_W-1:0]    r_qty;
    logic [QTY_W-1:0]    r_rem;
    logic [TRADER_W-1:0] r_who;
    logic [SEQ_W-1:0]    r_ord;
    logic [SEQ_W-1:0]    r_next_ord;
    logic [SEQ_W-1:0]    r_next_trd;
    logic [CW-1:0]       r_nfill;

    logic [CW-1:0]       r_scan;
    logic                r_cmp_vld;
    logic [AW-1:0]       r_cmp_idx;
    t_entry              r_rd;

    logic                r_found;
    logic [AW-1:0]       r_best_idx;
    t_entry              r_best;
    logic [SEQ_W-1:0]    r_best_age;

    logic                r_out_valid;
    t_result             r_out;

    logic [BOOK_DEPTH-1:0] opp_vld;
    logic [BOOK_DEPTH-1:0] own_vld;
    logic                  scan_go;
    logic [MW-1:0]         rd_addr;
    logic [MW-1:0]         best_addr;
    logic [MW-1:0]         rest_addr;
    logic [SEQ_W-1:0]      cand_age;
    logic                  cand_ok;
    logic                  cand_better;
    logic [QTY_W-1:0]      fill_qty;
    logic [QTY_W-1:0]      maker_left;
    logic                  free_found;
    logic [AW-1:0]         free_idx;
    logic [1:0]            fin_status;
    logic                  do_rest;
    logic                  out_free;

    function automatic logic [MW-1:0] f_addr(input logic side, input logic [AW-1:0] idx);
        logic [MW-1:0] base;
        base = side ? ASK_BASE : '0;
        return base + MW'(idx);
    endfunction

    // A sell takes bids, a buy takes asks.
    assign opp_vld = r_side ? r_bid_vld : r_ask_vld;
    assign own_vld = r_side ? r_ask_vld : r_bid_vld;

    assign scan_go   = i_cmd.scan_run && (r_scan != DEPTH_C);
    assign rd_addr   = f_addr(~r_side, r_scan[AW-1:0]);
    assign best_addr = f_addr(~r_side, r_best_idx);
    assign rest_addr = f_addr(r_side, free_idx);

    assign cand_age = r_ord - r_rd.seq;
    assign cand_ok  = opp_vld[r_cmp_idx] &&
                      (r_kind || (r_side ? (r_rd.price >= r_limit)
                                         : (r_rd.price <= r_limit)));
    assign cand_better = !r_found ||
                         ((r_rd.price != r_best.price) &&
                          (r_side ? (r_rd.price > r_best.price)
                                  : (r_rd.price < r_best.price))) ||
                         ((r_rd.price == r_best.price) && (cand_age > r_best_age));

    assign fill_qty   = (r_rem < r_best.remaining) ? r_rem : r_best.remaining;
    assign maker_left = r_best.remaining - fill_qty;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
            if (!own_vld[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    always_comb begin
        do_rest = 1'b0;
        if (r_rem == '0) begin
            fin_status = ST_FILLED;
        end else if (r_kind == KIND_MARKET) begin
            fin_status = ST_PARTIAL;
        end else if (!free_found) begin
            fin_status = ST_REJECTED;
        end else begin
            do_rest    = 1'b1;
            fin_status = (r_rem < r_qty) ? ST_PARTIAL : ST_OPEN;
        end
    end

    assign out_free = !r_out_valid;

    assign o_sts.scan_done = (r_scan == DEPTH_C) && !r_cmp_vld;
    assign o_sts.found     = r_found;
    assign o_sts.more      = (r_rem != '0) && (r_nfill < DEPTH_C);
    assign o_sts.out_free  = out_free;

    // Book store: one read for the scan, one write for a fill or a rest.
    always_ff @(posedge i_clk) begin
        if (scan_go) begin
            r_rd <= r_mem[rd_addr];
        end
        if (i_cmd.fill) begin
            r_mem[best_addr] <= '{price: r_best.price, remaining: maker_left,
                                  owner: r_best.owner, seq: r_best.seq};
        end else if (i_cmd.report && do_rest) begin
            r_mem[rest_addr] <= '{price: r_limit, remaining: r_rem,
                                  owner: r_who, seq: r_ord};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid_vld   <= '0;
            r_ask_vld   <= '0;
            r_next_ord  <= SEQ_W'(1);
            r_next_trd  <= SEQ_W'(1);
            r_nfill     <= '0;
            r_scan      <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= scan_go;
            if (i_cmd.load) begin
                r_next_ord <= r_next_ord + SEQ_W'(1);
                r_nfill    <= '0;
            end
            if (i_cmd.scan_init) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end else if (scan_go) begin
                r_scan <= r_scan + CW'(1);
            end
            if (r_cmp_vld && cand_ok && cand_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.fill) begin
                r_next_trd <= r_next_trd + SEQ_W'(1);
                r_nfill    <= r_nfill + CW'(1);
                if (maker_left == '0) begin
                    if (r_side) r_bid_vld[r_best_idx] <= 1'b0;
                    else        r_ask_vld[r_best_idx] <= 1'b0;
                end
            end
            if (i_cmd.report && do_rest) begin
                if (r_side) r_ask_vld[free_idx] <= 1'b1;
                else        r_bid_vld[free_idx] <= 1'b1;
            end
            if (i_cmd.fill || i_cmd.report) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan[AW-1:0];
        if (i_cmd.load) begin
            r_kind  <= i_order.kind;
            r_side  <= i_order.side;
            r_limit <= i_order.price;
            r_qty   <= i_order.quantity;
            r_rem   <= i_order.quantity;
            r_who   <= i_order.trader;
            r_ord   <= r_next_ord;
        end
        if (r_cmp_vld && cand_ok && cand_better) begin
            r_best_idx <= r_cmp_idx;
            r_best     <= r_rd;
            r_best_age <= cand_age;
        end
        if (i_cmd.fill) begin
            r_rem <= r_rem - fill_qty;
            r_out <= '{result_type: RES_TRADE, order_number: r_ord,
                       trade_number: r_next_trd, maker_trader: r_best.owner,
                       maker_order: r_best.seq, taker_trader: r_who,
                       taker_dir: r_side, fill_price: r_best.price,
                       trade_qty: fill_qty, order_status: ST_OPEN, last: 1'b0};
        end else if (i_cmd.report) begin
            r_out <= '{result_type: RES_FINAL, order_number: r_ord,
                       trade_number: '0, maker_trader: '0, maker_order: '0,
                       taker_trader: r_who, taker_dir: r_side, fill_price: '0,
                       trade_qty: '0, order_status: fin_status, last: 1'b1};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* src/limit_order_book_matcher_top.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Price-time priority matcher over a bounded two-sided order book.
// ----------------------------------------------------------------------------
// Usage: an order is offered on i_in_valid / i_in_data and transfers when
// o_in_stall is low. The block then works on that order alone and holds
// o_in_stall high until its final report has been loaded into the output
// register. Results leave on o_out_valid / o_out_data, one trade per fill and
// then one final report with last set; i_out_stall holds the current result
// and the matcher waits to load the next one until it transfers.
// Sequence: each fill takes a check state, a full scan of the opposite book
// side through the single read port of the book store (with its start and
// decision states) and a fill state that loads the trade. An order ends
// after its last fill when it is filled or at the fill limit; otherwise a
// further scan that finds no maker comes first. An order with a zero
// quantity goes from its check straight to its final report, with no scan.
// Reset: both book sides empty, order and trade numbers restart at one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module limit_order_book_matcher_top
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = 32
)(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_order  i_in_data,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_result      o_out_data,
    input  wire logic    i_out_stall
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    out_trade;

    lobm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lobm_dp #(
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_order     (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign out_trade = o_out_valid && (o_out_data.result_type == RES_TRADE);

    `LOBM_ASSERT(a_busy_after_take, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `LOBM_ASSERT(a_last_on_final, o_out_valid |-> (o_out_data.last == o_out_data.result_type))
    `LOBM_ASSERT(a_trade_nonzero, out_trade |-> (o_out_data.trade_qty != '0))

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives limit and market orders into the order book matcher and checks every
// trade and final report against a price-time priority book kept alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

import lobm_pkg::*;

class book_scoreboard;
    logic [PRICE_W-1:0]  bk_price [2][32];
    logic [QTY_W-1:0]    bk_rem   [2][32];
    logic [TRADER_W-1:0] bk_owner [2][32];
    logic [SEQ_W-1:0]    bk_seq   [2][32];
    bit                  bk_live  [2][32];
    logic [SEQ_W-1:0]    order_no;
    logic [SEQ_W-1:0]    trade_no;
    t_result             pending[$];
    int                  errors;
    int                  trades_seen;
    int                  finals_seen;
    int                  status_seen[4];

    function new();
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < 32; i++) bk_live[s][i] = 0;
        order_no = 1;
        trade_no = 1;
        errors = 0;
        trades_seen = 0;
        finals_seen = 0;
        for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    // Works out the trades and the final report that one accepted order causes.
    function void note_order(t_order o);
        t_result r;
        logic [SEQ_W-1:0] ord;
        logic [QTY_W-1:0] left, fill;
        logic [PRICE_W-1:0] bp;
        logic [SEQ_W-1:0] bage, age;
        int opp, own, best, nfill, slot;
        bit sell;
        sell = (o.side == SIDE_SELL);
        opp = sell ? 0 : 1;
        own = sell ? 1 : 0;
        ord = order_no;
        order_no = ord + 1;
        left = o.quantity;
        nfill = 0;
        while (left != 0 && nfill < 32) begin
            best = -1;
            bp = 0;
            bage = 0;
            for (int i = 0; i < 32; i++) begin
                if (!bk_live[opp][i]) continue;
                if (o.kind == KIND_LIMIT &&
                    (sell ? (bk_price[opp][i] < o.price) : (bk_price[opp][i] > o.price)))
                    continue;
                age = ord - bk_seq[opp][i];
                if (best < 0 ||
                    (bk_price[opp][i] != bp &&
                     (sell ? (bk_price[opp][i] > bp) : (bk_price[opp][i] < bp))) ||
                    (bk_price[opp][i] == bp && age > bage)) begin
                    best = i;
                    bp = bk_price[opp][i];
                    bage = age;
                end
            end
            if (best < 0) break;
            fill = (left < bk_rem[opp][best]) ? left : bk_rem[opp][best];
            r = '0;
            r.result_type   = RES_TRADE;
            r.order_number  = ord;
            r.trade_number  = trade_no;
            r.maker_trader  = bk_owner[opp][best];
            r.maker_order   = bk_seq[opp][best];
            r.taker_trader  = o.trader;
            r.taker_dir     = o.side;
            r.fill_price    = bp;
            r.trade_qty     = fill;
            pending.insert(pending.size(), r);
            nfill++;
            trade_no++;
            left -= fill;
            bk_rem[opp][best] -= fill;
            if (bk_rem[opp][best] == 0) bk_live[opp][best] = 0;
        end
        r = '0;
        r.result_type  = RES_FINAL;
        r.order_number = ord;
        r.taker_trader = o.trader;
        r.taker_dir    = o.side;
        r.last         = 1'b1;
        if (left == 0) begin
            r.order_status = ST_FILLED;
        end else if (o.kind == KIND_MARKET) begin
            r.order_status = ST_PARTIAL;
        end else begin
            slot = -1;
            for (int i = 0; i < 32; i++)
                if (!bk_live[own][i]) begin
                    slot = i;
                    break;
                end
            if (slot < 0) begin
                r.order_status = ST_REJECTED;
            end else begin
                bk_price[own][slot] = o.price;
                bk_rem[own][slot]   = left;
                bk_owner[own][slot] = o.trader;
                bk_seq[own][slot]   = ord;
                bk_live[own][slot]  = 1;
                r.order_status = (left < o.quantity) ? ST_PARTIAL : ST_OPEN;
            end
        end
        pending.insert(pending.size(), r);
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.result_type == RES_TRADE) trades_seen++;
        else begin
            finals_seen++;
            status_seen[got.order_status]++;
        end
        if (got !== want) begin
            $display("%0t: result mismatch", $time);
            $display("  expected type %0d ord %0d trd %0d mkr %0d/%0d tkr %0d side %0d",
                     want.result_type, want.order_number, want.trade_number,
                     want.maker_trader, want.maker_order, want.taker_trader,
                     want.taker_dir);
            $display("    px %0d qty %0d st %0d last %0d", want.fill_price,
                     want.trade_qty, want.order_status, want.last);
            $display("  actual   type %0d ord %0d trd %0d mkr %0d/%0d tkr %0d side %0d",
                     got.result_type, got.order_number, got.trade_number,
                     got.maker_trader, got.maker_order, got.taker_trader,
                     got.taker_dir);
            $display("    px %0d qty %0d st %0d last %0d", got.fill_price,
                     got.trade_qty, got.order_status, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    t_order  i_in_data;
    logic    o_in_stall;
    logic    o_out_valid;
    t_result o_out_data;
    logic    i_out_stall;

    book_scoreboard board;
    bit  calm;            // no idling in the last part of the run
    int  holds_asked;     // long receiver hold-offs requested
    int  holds_done;      // long receiver hold-offs carried out
    int  quiet_cycles = 0;
    int  orders_sent;
    int  market_sent;

    limit_order_book_matcher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offers one order and waits for its transfer, with an optional random gap.
    // Valid stays high after a transfer until the next order or a drain.
    task automatic send_order(input t_order o);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= o;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_order(o);
        orders_sent++;
        if (o.kind == KIND_MARKET) market_sent++;
    endtask

    task automatic place(input logic k, input logic s, input logic [31:0] p,
                         input logic [31:0] q, input logic [15:0] t);
        t_order o;
        o.kind = k;
        o.side = s;
        o.price = p;
        o.quantity = q;
        o.trader = t;
        send_order(o);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // Prices cluster near 1000 so that orders cross often and ties occur.
    task automatic random_order();
        t_order o;
        o.kind = ($urandom_range(0, 5) == 0) ? KIND_MARKET : KIND_LIMIT;
        o.side = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       o.price = $urandom;
            1:       o.price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: o.price = 32'd990 + $urandom_range(0, 20);
        endcase
        case ($urandom_range(0, 9))
            0:       o.quantity = $urandom;
            1:       o.quantity = 32'd0;
            default: o.quantity = $urandom_range(1, 500);
        endcase
        o.trader = 16'($urandom);
        send_order(o);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_data);
    end

    // Receiver idling in bursts, plus a long hold-off on request.
    initial begin : receiver
        int n;
        holds_done = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_asked != holds_done) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_out_stall <= 1'b0;
                holds_done++;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
                n = $urandom_range(0, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("limit_order_book_matcher_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        board = new();
        calm = 0;
        holds_asked = 0;
        orders_sent = 0;
        market_sent = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero quantity, market into an empty book, extremes,
        // equal-price time priority, partial makers that stay matchable.
        place(KIND_LIMIT,  SIDE_BUY,  32'd100, 32'd0, 16'h0000);
        place(KIND_MARKET, SIDE_SELL, 32'd0, 32'd50, 16'hFFFF);
        place(KIND_LIMIT,  SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        place(KIND_LIMIT,  SIDE_SELL, 32'd500, 32'd10, 16'd1);
        place(KIND_LIMIT,  SIDE_SELL, 32'd500, 32'd20, 16'd2);
        place(KIND_LIMIT,  SIDE_SELL, 32'd400, 32'd5, 16'd3);
        place(KIND_LIMIT,  SIDE_BUY,  32'd450, 32'd8, 16'd4);
        place(KIND_LIMIT,  SIDE_BUY,  32'd500, 32'd12, 16'd5);
        place(KIND_LIMIT,  SIDE_BUY,  32'd0, 32'd7, 16'd6);
        place(KIND_MARKET, SIDE_BUY,  32'd0, 32'd30, 16'd7);
        place(KIND_LIMIT,  SIDE_SELL, 32'd0, 32'd100, 16'd8);
        place(KIND_MARKET, SIDE_SELL, 32'hFFFF_FFFF, 32'd1, 16'd9);
        place(KIND_MARKET, SIDE_BUY,  32'd0, 32'hFFFF_FFFF, 16'd10);
        drain();

        // Fill the bid side so that a further resting bid is rejected, then
        // sweep it with one large sell so that one order fills every maker.
        for (int i = 0; i < 33; i++)
            place(KIND_LIMIT, SIDE_BUY, 32'd10 + (i % 4), 32'd3, i[15:0]);
        place(KIND_MARKET, SIDE_SELL, 32'd0, 32'd200, 16'd77);
        drain();

        // Long output hold-off while orders keep coming.
        holds_asked = 1;
        for (int i = 0; i < 6; i++) random_order();
        drain();

        for (int i = 0; i < 100; i++) begin
            if (i == 80) begin
                drain();
                calm = 1;
            end
            random_order();
        end
        drain();
        repeat (200) @(posedge i_clk);

        $display("Sent %0d orders (%0d market); checked %0d trades and %0d reports.",
                 orders_sent, market_sent, board.trades_seen, board.finals_seen);
        $display("Report status counts: open %0d, partial %0d, filled %0d, rejected %0d.",
                 board.status_seen[0], board.status_seen[1], board.status_seen[2],
                 board.status_seen[3]);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("limit_order_book_matcher_top regression: pass");
        end else begin
            $display("limit_order_book_matcher_top regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
